// ----- rtl/vdi_pkg.sv -----
// Shared types and constants for the 3D distance and integer square root block.
package vdi_pkg;

    // Coordinate, magnitude, square and sum widths.
    localparam int COORD_W  = 31;
    localparam int SQUARE_W = 2 * COORD_W;
    localparam int SUM_W    = 64;

    // One root bit per cell; the radicand is consumed two bits per cell.
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int TRIAL_W  = REM_W + 2;

    // Work carried from one root cell to the next.
    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_beat_t;

endpackage

// ----- rtl/vector3_distance_isqrt.sv -----
// Top level: Euclidean distance of two Q15.16 3D points via a 32-cell root chain.
// Data path: difference, square and sum stages, then one cell per root bit.
// Throughput: one beat per cycle while no stall holds it; every stage and cell holds one item.
// Stalls collapse bubbles: an empty stage fills even while the ones after it are held.
// Reset: rst_n clears all stage valids at once; payload registers are not reset.
module vector3_distance_isqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [vdi_pkg::COORD_W-1:0] a_x,
    input  logic signed [vdi_pkg::COORD_W-1:0] a_y,
    input  logic signed [vdi_pkg::COORD_W-1:0] a_z,
    input  logic signed [vdi_pkg::COORD_W-1:0] b_x,
    input  logic signed [vdi_pkg::COORD_W-1:0] b_y,
    input  logic signed [vdi_pkg::COORD_W-1:0] b_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [vdi_pkg::ROOT_W-1:0]  distance
);

    logic                       prep_ready;
    logic                       sum_valid;
    logic [vdi_pkg::SUM_W-1:0]  sum;

    // Handshake and beat at each link of the root chain; link 0 feeds the first cell.
    logic                       link_valid [0:vdi_pkg::ROOT_W];
    logic                       link_ready [0:vdi_pkg::ROOT_W];
    vdi_pkg::sqrt_beat_t        link_beat  [0:vdi_pkg::ROOT_W];

    // Front end: differences, squares, sum.
    vdi_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (prep_ready),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .down_valid (sum_valid),
        .down_ready (link_ready[0]),
        .sum        (sum)
    );

    // Start each root with an empty remainder and root; the sum is the radicand.
    assign link_valid[0]     = sum_valid;
    assign link_beat[0].rad  = sum;
    assign link_beat[0].rem  = '0;
    assign link_beat[0].root = '0;

    // One cell per root bit, most significant first.
    for (genvar i = 0; i < vdi_pkg::ROOT_W; i++)
    begin : g_cell
        vdi_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[i]),
            .up_ready   (link_ready[i]),
            .up_beat    (link_beat[i]),
            .down_valid (link_valid[i+1]),
            .down_ready (link_ready[i+1]),
            .down_beat  (link_beat[i+1])
        );
    end

    // Last cell register doubles as the output register; hold it while stalled.
    assign link_ready[vdi_pkg::ROOT_W] = !out_stall;
    assign out_valid = link_valid[vdi_pkg::ROOT_W];
    assign distance  = link_beat[vdi_pkg::ROOT_W].root;

    // Stall the input only when every stage holds an item and the output is blocked.
    assign in_stall = !prep_ready;

`ifndef SYNTHESIS
    // A full pipe backs up only from a blocked result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // An open output leaves room for a new input beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is open");
`endif

endmodule

// ----- rtl/vdi_prep.sv -----
// Front end: component differences, squares and the 64-bit sum of squares.
module vdi_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   up_valid,
    output logic                                   up_ready,
    input  logic signed [vdi_pkg::COORD_W-1:0]     a_x,
    input  logic signed [vdi_pkg::COORD_W-1:0]     a_y,
    input  logic signed [vdi_pkg::COORD_W-1:0]     a_z,
    input  logic signed [vdi_pkg::COORD_W-1:0]     b_x,
    input  logic signed [vdi_pkg::COORD_W-1:0]     b_y,
    input  logic signed [vdi_pkg::COORD_W-1:0]     b_z,
    output logic                                   down_valid,
    input  logic                                   down_ready,
    output logic        [vdi_pkg::SUM_W-1:0]       sum
);

    // Exact |b - a|; the magnitude always fits the coordinate width.
    function automatic logic [vdi_pkg::COORD_W-1:0] abs_diff(
        input logic signed [vdi_pkg::COORD_W-1:0] a,
        input logic signed [vdi_pkg::COORD_W-1:0] b
    );
        logic signed [vdi_pkg::COORD_W:0] d;
        logic        [vdi_pkg::COORD_W:0] m;
        begin
            d = $signed({b[vdi_pkg::COORD_W-1], b}) - $signed({a[vdi_pkg::COORD_W-1], a});
            m = d[vdi_pkg::COORD_W] ? (~d + 1'b1) : d;
            return m[vdi_pkg::COORD_W-1:0];
        end
    endfunction

    logic                             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                             s1_ready, s2_ready, s3_ready;
    logic [vdi_pkg::COORD_W-1:0]      dx_reg, dy_reg, dz_reg;
    logic [vdi_pkg::SQUARE_W-1:0]     sqx_reg, sqy_reg, sqz_reg;
    logic [vdi_pkg::SUM_W-1:0]        sum_reg, sum_next;

    assign s3_ready = !s3_valid_reg || down_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    assign sum_next = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= up_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            dx_reg <= abs_diff(a_x, b_x);
            dy_reg <= abs_diff(a_y, b_y);
            dz_reg <= abs_diff(a_z, b_z);
        end
        if (s2_ready && s1_valid_reg)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            sqz_reg <= dz_reg * dz_reg;
        end
        if (s3_ready && s2_valid_reg)
            sum_reg <= sum_next;
    end

    assign down_valid = s3_valid_reg;
    assign sum        = sum_reg;

`ifndef SYNTHESIS
    // Three squares of 31-bit magnitudes stay below 3 * 2^62.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (sum_reg[vdi_pkg::SUM_W-1:vdi_pkg::SUM_W-2] != 2'b11))
        else $error("sum of squares out of range");
`endif

endmodule

// ----- rtl/vdi_cell.sv -----
// One root cell: resolves one bit of the integer square root per beat.
module vdi_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  vdi_pkg::sqrt_beat_t up_beat,
    output logic                down_valid,
    input  logic                down_ready,
    output vdi_pkg::sqrt_beat_t down_beat
);

    logic                          valid_reg;
    vdi_pkg::sqrt_beat_t           beat_reg, beat_next;
    logic [vdi_pkg::TRIAL_W-1:0]   shifted, trial;

    assign up_ready = !valid_reg || down_ready;

    // Bring down two radicand bits and try subtracting 4*root + 1.
    always_comb
    begin
        shifted = {up_beat.rem, up_beat.rad[vdi_pkg::SUM_W-1:vdi_pkg::SUM_W-2]};
        trial   = shifted - {2'b00, up_beat.root, 2'b01};
        beat_next.rad = {up_beat.rad[vdi_pkg::SUM_W-3:0], 2'b00};
        if (!trial[vdi_pkg::TRIAL_W-1])
        begin
            beat_next.rem  = trial[vdi_pkg::REM_W-1:0];
            beat_next.root = {up_beat.root[vdi_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            beat_next.rem  = shifted[vdi_pkg::REM_W-1:0];
            beat_next.root = {up_beat.root[vdi_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            beat_reg <= beat_next;
    end

    assign down_valid = valid_reg;
    assign down_beat  = beat_reg;

`ifndef SYNTHESIS
    // Remainder never exceeds twice the partial root.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, beat_reg.rem} <= {2'b00, beat_reg.root, 1'b0}))
        else $error("root cell remainder exceeds bound");
`endif

endmodule

// ----- verif/distance_checker.sv -----
// Scoreboard for the 3D distance block: predicts every distance and checks each result beat.
module distance_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic signed [vdi_pkg::COORD_W-1:0] a_x,
    input  logic signed [vdi_pkg::COORD_W-1:0] a_y,
    input  logic signed [vdi_pkg::COORD_W-1:0] a_z,
    input  logic signed [vdi_pkg::COORD_W-1:0] b_x,
    input  logic signed [vdi_pkg::COORD_W-1:0] b_y,
    input  logic signed [vdi_pkg::COORD_W-1:0] b_z,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic        [vdi_pkg::ROOT_W-1:0]  distance,
    output int unsigned                        distance_errors,
    output int unsigned                        distances_pending
);

    typedef logic signed [vdi_pkg::COORD_W-1:0] coord_t;
    typedef logic [vdi_pkg::ROOT_W-1:0]         root_t;

    root_t expected_distances[$];

    // Square of the exact difference along one axis; never wraps.
    function automatic logic [63:0] axis_square(input coord_t from_pt, input coord_t to_pt);
        longint      span;
        logic [63:0] mag;
        span = longint'(to_pt) - longint'(from_pt);
        mag  = (span < 0) ? -span : span;
        return mag * mag;
    endfunction

    // Build the floor root one bit at a time, keeping a bit while its square still fits.
    function automatic root_t floor_distance(input coord_t ax, input coord_t ay,
                                             input coord_t az, input coord_t bx,
                                             input coord_t by, input coord_t bz);
        logic [63:0] radicand;
        logic [63:0] trial;
        root_t       root;
        radicand = axis_square(ax, bx) + axis_square(ay, by) + axis_square(az, bz);
        root     = '0;
        for (int i = vdi_pkg::ROOT_W - 1; i >= 0; i--)
        begin
            trial = {32'd0, root | (root_t'(1) << i)};
            if (trial * trial <= radicand)
                root = root | (root_t'(1) << i);
        end
        return root;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_distances.delete();
            distance_errors   <= 0;
            distances_pending <= 0;
        end
        else
        begin
            // Retire first: a result can never belong to a beat taken at the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_distances.size() == 0)
                begin
                    $error("distance: unexpected result %0d with nothing pending", distance);
                    distance_errors <= distance_errors + 1;
                end
                else if (distance !== expected_distances[0])
                begin
                    $error("distance mismatch: expected %0d, actual %0d",
                           expected_distances[0], distance);
                    distance_errors <= distance_errors + 1;
                    void'(expected_distances.pop_front());
                end
                else
                begin
                    void'(expected_distances.pop_front());
                end
            end
            if (in_valid && !in_stall)
                expected_distances.push_back(floor_distance(a_x, a_y, a_z, b_x, b_y, b_z));
            distances_pending <= expected_distances.size();
        end
    end

endmodule

// ----- verif/vector3_distance_isqrt_tb.sv -----
// Testbench top for the 3D distance block: clock, reset, point-pair stimulus and verdict.
module vector3_distance_isqrt_tb;

    typedef logic signed [vdi_pkg::COORD_W-1:0] coord_t;

    // Shapes of random point pairs.
    typedef enum int {
        PAIR_ANY,
        PAIR_NEAR,
        PAIR_FROM_ORIGIN,
        PAIR_EDGE
    } pair_kind_t;

    localparam coord_t COORD_MAX       = {1'b0, {(vdi_pkg::COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN       = {1'b1, {(vdi_pkg::COORD_W-1){1'b0}}};
    localparam coord_t ONE             = coord_t'(65536);   // 1.0 in Q15.16
    localparam int     BULK_PAIRS      = 1600;
    localparam int     HOLD_OFF_CYCLES = 300;     // well past the 35-deep pipe
    localparam int     DRAIN_CYCLES    = 60;
    localparam int     IDLE_LIMIT      = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    coord_t      a_x;
    coord_t      a_y;
    coord_t      a_z;
    coord_t      b_x;
    coord_t      b_y;
    coord_t      b_z;
    logic        out_valid;
    logic        out_stall;
    logic [vdi_pkg::ROOT_W-1:0] distance;

    int unsigned distance_errors;
    int unsigned distances_pending;

    int burst_left;
    bit bulk_started;
    int stall_pct;
    int segment_len;
    int idle_cycles;

    vector3_distance_isqrt u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance)
    );

    distance_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .a_x               (a_x),
        .a_y               (a_y),
        .a_z               (a_z),
        .b_x               (b_x),
        .b_y               (b_y),
        .b_z               (b_z),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .distance          (distance),
        .distance_errors   (distance_errors),
        .distances_pending (distances_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a coordinate from the corners of the range, with a random one now and then.
    function automatic coord_t edge_coord();
        case ($urandom_range(5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return coord_t'(-1);
            4:       return coord_t'(1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Offer one point pair as a beat and hold it until the block takes it.
    // Bursts of random length; between bursts, usually a short gap with valid low,
    // sometimes none at all so back-to-back stretches occur too.
    task automatic offer_pair(input coord_t ax, input coord_t ay, input coord_t az,
                              input coord_t bx, input coord_t by, input coord_t bz);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            if ($urandom_range(3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(8, 1)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        a_x      <= ax;
        a_y      <= ay;
        a_z      <= az;
        b_x      <= bx;
        b_y      <= by;
        b_z      <= bz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stimulus: reset, a directed set of pairs, then the random bulk, then drain and verdict.
    initial
    begin
        pair_kind_t kind;
        coord_t     ax;
        coord_t     ay;
        coord_t     az;
        coord_t     bx;
        coord_t     by;
        coord_t     bz;
        int         pick;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        a_x          <= '0;
        a_y          <= '0;
        a_z          <= '0;
        b_x          <= '0;
        b_y          <= '0;
        b_z          <= '0;
        burst_left   = 0;
        bulk_started = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Identical points give zero, wherever they sit.
        offer_pair('0, '0, '0, '0, '0, '0);
        offer_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        offer_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        offer_pair(coord_t'(-1), ONE, COORD_MIN, coord_t'(-1), ONE, COORD_MIN);
        // Opposite corners: the largest sum the range allows, in both directions.
        offer_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        offer_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        offer_pair(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        // Full span along a single axis.
        offer_pair(COORD_MIN, '0, '0, COORD_MAX, '0, '0);
        offer_pair('0, COORD_MAX, '0, '0, COORD_MIN, '0);
        offer_pair('0, '0, COORD_MIN, '0, '0, COORD_MAX);
        // Vector length with one point at the origin.
        offer_pair('0, '0, '0, coord_t'(3 * ONE), coord_t'(4 * ONE), '0);
        offer_pair('0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX);
        offer_pair('0, '0, '0, COORD_MIN, COORD_MIN, COORD_MIN);
        offer_pair(ONE, coord_t'(2 * ONE), coord_t'(2 * ONE), '0, '0, '0);
        // Small differences; the smallest nonzero sums still root to one.
        offer_pair('0, '0, '0, coord_t'(1), '0, '0);
        offer_pair('0, '0, '0, coord_t'(-1), coord_t'(-1), coord_t'(-1));
        offer_pair(coord_t'(-1), coord_t'(-1), coord_t'(-1), '0, '0, '0);
        offer_pair('0, '0, '0, coord_t'(1), coord_t'(1), '0);
        offer_pair(coord_t'(2), '0, '0, '0, '0, '0);
        offer_pair(-ONE, -ONE, -ONE, ONE, ONE, ONE);

        // Random bulk; let the receiver start its long hold-off now.
        bulk_started = 1'b1;
        for (int n = 0; n < BULK_PAIRS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                kind = PAIR_ANY;
            else if (pick < 70)
                kind = PAIR_NEAR;
            else if (pick < 85)
                kind = PAIR_FROM_ORIGIN;
            else
                kind = PAIR_EDGE;

            ax = coord_t'($urandom);
            ay = coord_t'($urandom);
            az = coord_t'($urandom);
            bx = coord_t'($urandom);
            by = coord_t'($urandom);
            bz = coord_t'($urandom);
            case (kind)
                PAIR_NEAR:
                begin
                    // Close points: small roots, exact low-order bits.
                    bx = ax + coord_t'($urandom_range(511) - 256);
                    by = ay + coord_t'($urandom_range(511) - 256);
                    bz = az + coord_t'($urandom_range(511) - 256);
                end
                PAIR_FROM_ORIGIN:
                begin
                    ax = '0;
                    ay = '0;
                    az = '0;
                end
                PAIR_EDGE:
                begin
                    ax = edge_coord();
                    ay = edge_coord();
                    az = edge_coord();
                    bx = edge_coord();
                    by = edge_coord();
                    bz = edge_coord();
                end
                default:
                begin
                end
            endcase
            offer_pair(ax, ay, az, bx, by, bz);
        end
        in_valid <= 1'b0;

        // Drain: wait until every predicted distance came back, then watch for strays.
        @(posedge clk);
        while (distances_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (distance_errors == 0)
            $display("PASS vector3_distance_isqrt");
        else
            $display("FAIL vector3_distance_isqrt");
        $finish;
    end

    // Receiver: segments of random length, each with its own stall density,
    // from never stalling to stalling most cycles. Once the bulk is running,
    // hold off completely for a long stretch so the pipe fills and backs up.
    initial
    begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (bulk_started && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            else
            begin
                segment_len = $urandom_range(200, 20);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
                repeat (segment_len)
                begin
                    @(posedge clk);
                    out_stall <= ($urandom_range(99) < stall_pct);
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves a beat for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL vector3_distance_isqrt");
        $finish;
    end

endmodule
